// File: hdl/cave_automaton_stencil_3d_assert.svh
// ----------------------------------------------------------------------------
// Cave automaton stencil: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_STENCIL_3D_ASSERT_SVH
`define CAVE_AUTOMATON_STENCIL_3D_ASSERT_SVH

// property holds at every edge out of reset
`define CAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent at one edge implies consequent at the next
`define CAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/cas_pkg.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: package
// Sizes, register codes, reset values and the stage control word.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_DEPTH  = 64;

  // register field widths
  localparam int DIMW = 7;
  localparam int THRW = 5;
  localparam int CNTW = 5;

  // coordinate and store widths
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int PAW   = (PLANE > 1) ? $clog2(PLANE) : 1;
  localparam int RAW   = XW;
  localparam int WHW   = $clog2(PLANE + 1);
  localparam int LAGW  = $clog2(PLANE + MAX_WIDTH + 2);
  localparam int LINW  = $clog2(PLANE * MAX_DEPTH + PLANE + MAX_WIDTH + 2);

  // APB side
  localparam int ADDRW = 5;
  localparam int DATAW = 32;

  // register indexes
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GRID_DEPTH  = 3'd2;
  localparam logic [2:0] REG_STAY_MIN    = 3'd3;
  localparam logic [2:0] REG_BECOME_MIN  = 3'd4;

  // reset values
  localparam logic [DIMW-1:0] RST_WIDTH      = 7'd64;
  localparam logic [DIMW-1:0] RST_HEIGHT     = 7'd64;
  localparam logic [DIMW-1:0] RST_DEPTH      = 7'd1;
  localparam logic [THRW-1:0] RST_STAY_MIN   = 5'd4;
  localparam logic [THRW-1:0] RST_BECOME_MIN = 5'd5;

  // cycles for the derived sizes to follow a register write
  localparam logic [1:0] SETTLE = 2'd2;

  // control word carried alongside one shift of the window
  typedef struct packed {
    logic          shift;
    logic          emit;
    logic          last;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [ZW-1:0] z;
  } stage_t;

  // zero acts as one, oversize acts as the maximum
  function automatic logic [DIMW-1:0] clamp_dim(logic [DIMW-1:0] v, int maxv);
    logic [DIMW-1:0] r;
    if (v == '0) begin
      r = DIMW'(1);
    end else if (int'(v) > maxv) begin
      r = DIMW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/cas_if.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: stream interfaces
// Cell input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cas_in_if;
  logic valid;
  logic ready;
  logic cell_wall;
  logic padding;
  modport source (output valid, output cell_wall, output padding, input ready);
  modport sink   (input valid, input cell_wall, input padding, output ready);
endinterface

interface cas_out_if;
  logic valid;
  logic ready;
  logic next_wall;
  logic last_cell;
  modport source (output valid, output next_wall, output last_cell, input ready);
  modport sink   (input valid, input next_wall, input last_cell, output ready);
endinterface

`default_nettype wire

// File: hdl/cas_ram.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: simple dual-port RAM
// One write port, one read port with registered data (read gives old data).
// ----------------------------------------------------------------------------
`default_nettype none

module cas_ram #(
  parameter int Depth = 64,
  parameter int Width = 1,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/cas_delay_lines.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: plane and row delay lines
// Turns the cell stream into three planes by three rows of aligned bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_delay_lines (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   clr_i,
  input  wire cas_pkg::stage_t        ctl_i,
  input  wire logic                   bit_i,
  input  wire logic [cas_pkg::DIMW-1:0] w_i,
  input  wire logic [cas_pkg::WHW-1:0]  wh_i,
  output logic [2:0][2:0]             rows_o,
  output cas_pkg::stage_t             ctl_o
);

  cas_pkg::stage_t ctl_a_q, ctl_b_q;
  logic [cas_pkg::PAW-1:0] pptr_q, pptr_prev_q;
  logic [cas_pkg::RAW-1:0] rptr_q, rptr_prev_q;
  logic       s0_q, pbyp_q, pbyp_data_q;
  logic       p1, p2_rd, s2;
  logic [2:0] trip, r0_q, r1, r2_rd, rbyp_data_q;
  logic       rbyp_q;
  logic       sh_a, sh_b;

  assign sh_a = en_i && ctl_i.shift;
  assign sh_b = en_i && ctl_a_q.shift;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  // circular pointers, cleared when the grid size changes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pptr_q      <= '0;
      pptr_prev_q <= '0;
      rptr_q      <= '0;
      rptr_prev_q <= '0;
    end else if (clr_i) begin
      pptr_q      <= '0;
      pptr_prev_q <= '0;
      rptr_q      <= '0;
      rptr_prev_q <= '0;
    end else begin
      if (sh_a) begin
        pptr_prev_q <= pptr_q;
        pptr_q <= (cas_pkg::WHW'(pptr_q) == wh_i - cas_pkg::WHW'(1)) ? '0 : pptr_q + 1'b1;
      end
      if (sh_b) begin
        rptr_prev_q <= rptr_q;
        rptr_q <= (cas_pkg::DIMW'(rptr_q) == w_i - cas_pkg::DIMW'(1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  // plane stage: first and second plane delay
  cas_ram #(.Depth(cas_pkg::PLANE), .Width(1)) u_plane1 (
    .clk_i, .we_i(sh_a), .waddr_i(pptr_q), .wdata_i(bit_i),
    .re_i(sh_a), .raddr_i(pptr_q), .rdata_o(p1)
  );

  // second delay writes one beat late, so it bypasses when both hit one entry
  cas_ram #(.Depth(cas_pkg::PLANE), .Width(1)) u_plane2 (
    .clk_i, .we_i(sh_a), .waddr_i(pptr_prev_q), .wdata_i(p1),
    .re_i(sh_a), .raddr_i(pptr_q), .rdata_o(p2_rd)
  );

  always_ff @(posedge clk_i) begin
    if (sh_a) begin
      s0_q        <= bit_i;
      pbyp_q      <= (pptr_q == pptr_prev_q);
      pbyp_data_q <= p1;
    end
  end

  assign s2   = pbyp_q ? pbyp_data_q : p2_rd;
  assign trip = {s2, p1, s0_q};

  // row stage: same scheme, one row apart, three planes wide
  cas_ram #(.Depth(cas_pkg::MAX_WIDTH), .Width(3)) u_row1 (
    .clk_i, .we_i(sh_b), .waddr_i(rptr_q), .wdata_i(trip),
    .re_i(sh_b), .raddr_i(rptr_q), .rdata_o(r1)
  );

  cas_ram #(.Depth(cas_pkg::MAX_WIDTH), .Width(3)) u_row2 (
    .clk_i, .we_i(sh_b), .waddr_i(rptr_prev_q), .wdata_i(r1),
    .re_i(sh_b), .raddr_i(rptr_q), .rdata_o(r2_rd)
  );

  always_ff @(posedge clk_i) begin
    if (sh_b) begin
      r0_q        <= trip;
      rbyp_q      <= (rptr_q == rptr_prev_q);
      rbyp_data_q <= r1;
    end
  end

  // rows_o[plane][row]
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rows_o[a][0] = r0_q[a];
      rows_o[a][1] = r1[a];
      rows_o[a][2] = rbyp_q ? rbyp_data_q[a] : r2_rd[a];
    end
  end

  assign ctl_o = ctl_b_q;

endmodule

`default_nettype wire

// File: hdl/cas_tap_cell.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: window cell
// One bit of the 3x3x3 window; takes its neighbour's bit on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_tap_cell (
  input  wire logic clk_i,
  input  wire logic shift_i,
  input  wire logic d_i,
  output logic      q_o
);

  logic q_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// File: hdl/cas_rule.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: rule and output register
// Counts wall neighbours of the centre cell and applies the 4-5 style rule.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_rule (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire cas_pkg::stage_t          ctl_i,
  input  wire logic [2:0][2:0][2:0]     win_i,
  input  wire logic [cas_pkg::DIMW-1:0] w_i,
  input  wire logic [cas_pkg::DIMW-1:0] h_i,
  input  wire logic [cas_pkg::DIMW-1:0] d_i,
  input  wire logic [cas_pkg::THRW-1:0] stay_i,
  input  wire logic [cas_pkg::THRW-1:0] become_i,
  input  wire logic                     ready_i,
  output logic                          valid_o,
  output logic                          next_o,
  output logic                          last_o
);

  logic [26:0] nb;
  logic [cas_pkg::CNTW-1:0] count;
  logic centre, next_c;
  logic wx, wy, wz;
  logic [2:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic valid_q, next_q, last_q;

  assign wx = (w_i != cas_pkg::DIMW'(1));
  assign wy = (h_i != cas_pkg::DIMW'(1));
  assign wz = (d_i != cas_pkg::DIMW'(1));

  // border flags per axis: index 0 is offset -1, index 2 is offset +1
  always_comb begin
    lo_x = {1'b0, 1'b0, ctl_i.x == '0};
    hi_x = {cas_pkg::DIMW'(ctl_i.x) == w_i - cas_pkg::DIMW'(1), 1'b0, 1'b0};
    lo_y = {1'b0, 1'b0, ctl_i.y == '0};
    hi_y = {cas_pkg::DIMW'(ctl_i.y) == h_i - cas_pkg::DIMW'(1), 1'b0, 1'b0};
    lo_z = {1'b0, 1'b0, ctl_i.z == '0};
    hi_z = {cas_pkg::DIMW'(ctl_i.z) == d_i - cas_pkg::DIMW'(1), 1'b0, 1'b0};
  end

  // neighbour bits: outside counts as wall, single-cell axes add nothing
  always_comb begin
    int ta, tb, tc;
    nb = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          ta = wz ? 2 - i : 0;
          tb = wy ? 2 - j : 0;
          tc = wx ? 2 - k : 0;
          if ((wz || i == 1) && (wy || j == 1) && (wx || k == 1) &&
              !(i == 1 && j == 1 && k == 1)) begin
            if (lo_z[i] || hi_z[i] || lo_y[j] || hi_y[j] || lo_x[k] || hi_x[k]) begin
              nb[i*9 + j*3 + k] = 1'b1;
            end else begin
              nb[i*9 + j*3 + k] = win_i[ta][tb][tc];
            end
          end
        end
      end
    end
  end

  assign count  = cas_pkg::CNTW'($countones(nb));
  assign centre = win_i[wz ? 1 : 0][wy ? 1 : 0][wx ? 1 : 0];
  assign next_c = centre ? (count >= stay_i) : (count >= become_i);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i && ctl_i.emit) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.emit) begin
      next_q <= next_c;
      last_q <= ctl_i.last;
    end
  end

  assign valid_o = valid_q;
  assign next_o  = next_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// File: hdl/cave_automaton_stencil_3d.sv
// Path: an item passes the delay-line control registers, the window control register and
// the rule output register. Throughput: one cell per cycle unless the output stalls or
// sizes settle; the first result needs W*H + W + 2 cells (fewer on flat axes), then each
// stored cell, or each beat once the grid is in, yields one result. The rate is set by
// the single-shift plane and row delay RAMs and the 27-cell window. Reset: registers
// take their defaults; input is held off after reset and any write while grid sizes settle.
// ----------------------------------------------------------------------------
// Cave automaton stencil: top level
// Raster position tracking, APB registers and the stencil pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cave_automaton_stencil_3d_assert.svh"

module cave_automaton_stencil_3d (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cas_in_if.sink                         cell_i,
  cas_out_if.source                      result_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cas_pkg::ADDRW-1:0] paddr,
  input  wire logic [cas_pkg::DATAW-1:0] pwdata,
  output logic      [cas_pkg::DATAW-1:0] prdata,
  output logic                           pready
);

  logic [cas_pkg::DIMW-1:0] grid_width_q, grid_height_q, grid_depth_q;
  logic [cas_pkg::THRW-1:0] stay_q, become_q;
  logic [cas_pkg::DIMW-1:0] w_c, h_c, d_c;
  logic [cas_pkg::WHW-1:0]  wh_q;
  logic [cas_pkg::LAGW-1:0] lag_q;
  logic [cas_pkg::LINW-1:0] total_q;
  logic [1:0]               settle_q;
  logic [2:0]               reg_idx;
  logic                     wr, dim_wr;

  logic [cas_pkg::LINW-1:0] in_lin_q, out_lin_q, in_n;
  logic [cas_pkg::XW-1:0]   out_x_q;
  logic [cas_pkg::YW-1:0]   out_y_q;
  logic [cas_pkg::ZW-1:0]   out_z_q;
  logic store, emit_c, last_c, acc, en;

  cas_pkg::stage_t ctl0, ctl_b, ctl_c_q;
  logic [2:0][2:0]      rows;
  logic [2:0][2:0][2:0] win;
  logic out_valid;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign dim_wr  = wr && (reg_idx == cas_pkg::REG_GRID_WIDTH ||
                          reg_idx == cas_pkg::REG_GRID_HEIGHT ||
                          reg_idx == cas_pkg::REG_GRID_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= cas_pkg::RST_WIDTH;
      grid_height_q <= cas_pkg::RST_HEIGHT;
      grid_depth_q  <= cas_pkg::RST_DEPTH;
      stay_q        <= cas_pkg::RST_STAY_MIN;
      become_q      <= cas_pkg::RST_BECOME_MIN;
    end else if (wr) begin
      unique case (reg_idx)
        cas_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[cas_pkg::DIMW-1:0];
        cas_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[cas_pkg::DIMW-1:0];
        cas_pkg::REG_GRID_DEPTH:  grid_depth_q  <= pwdata[cas_pkg::DIMW-1:0];
        cas_pkg::REG_STAY_MIN:    stay_q        <= pwdata[cas_pkg::THRW-1:0];
        cas_pkg::REG_BECOME_MIN:  become_q      <= pwdata[cas_pkg::THRW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cas_pkg::REG_GRID_WIDTH:  prdata = cas_pkg::DATAW'(grid_width_q);
      cas_pkg::REG_GRID_HEIGHT: prdata = cas_pkg::DATAW'(grid_height_q);
      cas_pkg::REG_GRID_DEPTH:  prdata = cas_pkg::DATAW'(grid_depth_q);
      cas_pkg::REG_STAY_MIN:    prdata = cas_pkg::DATAW'(stay_q);
      cas_pkg::REG_BECOME_MIN:  prdata = cas_pkg::DATAW'(become_q);
      default:                  prdata = '0;
    endcase
  end

  // derived sizes: width times height is registered, then total and lag follow from it
  assign w_c = cas_pkg::clamp_dim(grid_width_q, cas_pkg::MAX_WIDTH);
  assign h_c = cas_pkg::clamp_dim(grid_height_q, cas_pkg::MAX_HEIGHT);
  assign d_c = cas_pkg::clamp_dim(grid_depth_q, cas_pkg::MAX_DEPTH);

  always_ff @(posedge clk_i) begin
    wh_q    <= cas_pkg::WHW'(w_c) * cas_pkg::WHW'(h_c);
    total_q <= cas_pkg::LINW'(wh_q) * cas_pkg::LINW'(d_c);
    lag_q   <= ((d_c != cas_pkg::DIMW'(1)) ? cas_pkg::LAGW'(wh_q) : '0) +
               ((h_c != cas_pkg::DIMW'(1)) ? cas_pkg::LAGW'(w_c) : '0) +
               cas_pkg::LAGW'(w_c != cas_pkg::DIMW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= cas_pkg::SETTLE;
    end else if (wr) begin
      settle_q <= cas_pkg::SETTLE;
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // pipeline advances unless a result would land on a full output register that is not being read
  assign en = !out_valid || result_o.ready || !ctl_c_q.emit;
  assign cell_i.ready = en && (settle_q == '0);
  assign acc = cell_i.valid && cell_i.ready;

  // stream position and emit decision
  assign store  = !cell_i.padding && (in_lin_q < total_q);
  assign in_n   = in_lin_q + cas_pkg::LINW'(store);
  assign emit_c = (in_n >= total_q) ||
                  (in_n >= out_lin_q + cas_pkg::LINW'(lag_q) + cas_pkg::LINW'(1));
  assign last_c = (out_lin_q == total_q - cas_pkg::LINW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_lin_q  <= '0;
      out_lin_q <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
    end else if (dim_wr || (acc && emit_c && last_c)) begin
      in_lin_q  <= '0;
      out_lin_q <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
    end else if (acc) begin
      in_lin_q <= in_n;
      if (emit_c) begin
        out_lin_q <= out_lin_q + cas_pkg::LINW'(1);
        if (cas_pkg::DIMW'(out_x_q) == w_c - cas_pkg::DIMW'(1)) begin
          out_x_q <= '0;
          if (cas_pkg::DIMW'(out_y_q) == h_c - cas_pkg::DIMW'(1)) begin
            out_y_q <= '0;
            out_z_q <= out_z_q + 1'b1;
          end else begin
            out_y_q <= out_y_q + 1'b1;
          end
        end else begin
          out_x_q <= out_x_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl0.shift = acc && (store || emit_c);
    ctl0.emit  = acc && emit_c;
    ctl0.last  = last_c;
    ctl0.x     = out_x_q;
    ctl0.y     = out_y_q;
    ctl0.z     = out_z_q;
  end

  // plane and row delays
  cas_delay_lines u_delay (
    .clk_i, .rst_ni, .en_i(en), .clr_i(dim_wr),
    .ctl_i(ctl0), .bit_i(cell_i.cell_wall && store),
    .w_i(w_c), .wh_i(wh_q), .rows_o(rows), .ctl_o(ctl_b)
  );

  // window: nine chains of three cells, newest at index 0
  for (genvar a = 0; a < 3; a++) begin : g_plane
    for (genvar b = 0; b < 3; b++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
        if (c == 0) begin : g_head
          cas_tap_cell u_cell (
            .clk_i, .shift_i(en && ctl_b.shift), .d_i(rows[a][b]), .q_o(win[a][b][c])
          );
        end else begin : g_tail
          cas_tap_cell u_cell (
            .clk_i, .shift_i(en && ctl_b.shift), .d_i(win[a][b][c-1]), .q_o(win[a][b][c])
          );
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
    end else if (en) begin
      ctl_c_q <= ctl_b;
    end
  end

  // neighbour count and rule
  cas_rule u_rule (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_c_q), .win_i(win),
    .w_i(w_c), .h_i(h_c), .d_i(d_c), .stay_i(stay_q), .become_i(become_q),
    .ready_i(result_o.ready), .valid_o(out_valid),
    .next_o(result_o.next_wall), .last_o(result_o.last_cell)
  );

  assign result_o.valid = out_valid;

  // checks
  `CAS_ASSERT(a_in_bound, clk_i, rst_ni, ((settle_q == '0) |-> (in_lin_q <= total_q)), "input position beyond grid")
  `CAS_ASSERT(a_out_bound, clk_i, rst_ni, ((settle_q == '0) |-> (out_lin_q < total_q)), "output position beyond grid")
  `CAS_ASSERT_NEXT(a_last_restart, clk_i, rst_ni, acc && emit_c && last_c, (in_lin_q == '0) && (out_lin_q == '0), "no restart after last cell")

endmodule

`default_nettype wire

// File: bench/cas_checker.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: result checker
// Watches the cell and result channels and the register port. It keeps its
// own model of the 3-D stencil and compares every result beat, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cas_in_if                                  cell_ch,
  cas_out_if                                 result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [cas_pkg::ADDRW-1:0]          paddr,
  input  logic [cas_pkg::DATAW-1:0]          pwdata,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE =
    2 * (cas_pkg::MAX_WIDTH * cas_pkg::MAX_HEIGHT + cas_pkg::MAX_WIDTH + 1) + 1;

  typedef struct packed {
    logic next_wall;
    logic last_cell;
  } cave_res_t;

  cave_res_t   next_state_q[$];
  bit          cell_store [STORE];
  int unsigned width_r, height_r, depth_r, stay_r, become_r;
  int unsigned in_x, in_y, in_z, out_x, out_y, out_z;

  assign pending = next_state_q.size();

  // zero acts as one, oversize as the maximum
  function automatic int unsigned eff_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic restart_raster();
    in_x = 0; in_y = 0; in_z = 0;
    out_x = 0; out_y = 0; out_z = 0;
  endtask

  // one accepted cell beat: store it and work out whether a cell is now due
  task automatic predict_next_state(logic wall, logic pad);
    int unsigned w, h, d, total, in_lin, out_lin, lag, cnt, lin;
    int          nx, ny, nz;
    bit          ctr, nw;
    cave_res_t   r;
    w = eff_dim(width_r, cas_pkg::MAX_WIDTH);
    h = eff_dim(height_r, cas_pkg::MAX_HEIGHT);
    d = eff_dim(depth_r, cas_pkg::MAX_DEPTH);
    total = w * h * d;
    in_lin = in_x + w * (in_y + h * in_z);
    if (!pad && in_z < d) begin
      cell_store[in_lin % STORE] = wall;
      in_x++;
      if (in_x >= w) begin
        in_x = 0; in_y++;
        if (in_y >= h) begin
          in_y = 0; in_z++;
        end
      end
      in_lin++;
    end
    out_lin = out_x + w * (out_y + h * out_z);
    lag = (d > 1 ? w * h : 0) + (h > 1 ? w : 0) + (w > 1 ? 1 : 0);
    if (!(in_lin >= total || in_lin >= out_lin + lag + 1)) return;
    cnt = 0;
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if ((d == 1 && dz != 0) || (h == 1 && dy != 0) || (w == 1 && dx != 0)) continue;
          if (dx == 0 && dy == 0 && dz == 0) continue;
          nx = int'(out_x) + dx;
          ny = int'(out_y) + dy;
          nz = int'(out_z) + dz;
          // outside the grid counts as wall
          if (nx < 0 || ny < 0 || nz < 0 || nx >= int'(w) || ny >= int'(h) || nz >= int'(d)) begin
            cnt++;
          end else begin
            lin = nx + w * (ny + h * nz);
            if (cell_store[lin % STORE]) cnt++;
          end
        end
      end
    end
    ctr = cell_store[out_lin % STORE];
    nw = ctr ? (cnt >= stay_r) : (cnt >= become_r);
    r.next_wall = nw;
    r.last_cell = (out_lin == total - 1);
    next_state_q.push_back(r);
    if (out_lin == total - 1) begin
      restart_raster();
    end else begin
      out_x++;
      if (out_x >= w) begin
        out_x = 0; out_y++;
        if (out_y >= h) begin
          out_y = 0; out_z++;
        end
      end
    end
  endtask

  // sample everything at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    cave_res_t e;
    if (!rst_ni) begin
      width_r = 32'(cas_pkg::RST_WIDTH);
      height_r = 32'(cas_pkg::RST_HEIGHT);
      depth_r = 32'(cas_pkg::RST_DEPTH);
      stay_r = 32'(cas_pkg::RST_STAY_MIN);
      become_r = 32'(cas_pkg::RST_BECOME_MIN);
      restart_raster();
      next_state_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      // result beat against the oldest expectation
      if (result.valid && result.ready) begin
        results_seen++;
        if (next_state_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = next_state_q.pop_front();
          if (e.next_wall !== result.next_wall)
            report($sformatf("next_wall expected %0b, got %0b", e.next_wall, result.next_wall));
          if (e.last_cell !== result.last_cell)
            report($sformatf("last_cell expected %0b, got %0b", e.last_cell, result.last_cell));
        end
      end
      if (cell_ch.valid && cell_ch.ready) predict_next_state(cell_ch.cell_wall, cell_ch.padding);
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[cas_pkg::ADDRW-1:2])
          cas_pkg::REG_GRID_WIDTH: begin
            width_r = 32'(pwdata[6:0]); restart_raster();
          end
          cas_pkg::REG_GRID_HEIGHT: begin
            height_r = 32'(pwdata[6:0]); restart_raster();
          end
          cas_pkg::REG_GRID_DEPTH: begin
            depth_r = 32'(pwdata[6:0]); restart_raster();
          end
          cas_pkg::REG_STAY_MIN:   stay_r   = 32'(pwdata[4:0]);
          cas_pkg::REG_BECOME_MIN: become_r = 32'(pwdata[4:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Cave automaton stencil: testbench top
// Streams generations of wall/floor grids of many shapes through the block,
// with padding drains, noise beats, cut-short grids and random stalls on both
// channels; a side checker predicts each next-state beat and counts failures.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [cas_pkg::ADDRW-1:0] paddr = '0;
  logic [cas_pkg::DATAW-1:0] pwdata = '0;
  logic [cas_pkg::DATAW-1:0] prdata;
  logic                      pready;
  int                        fail_count, pending, results_seen;
  int                        cells_sent = 0, generations = 0, idle_cycles = 0;
  bit                        quiet = 0, hold_off = 0;

  cas_in_if  cell_bus ();
  cas_out_if res_bus ();

  initial begin
    cell_bus.valid = 1'b0;
    cell_bus.cell_wall = 1'b0;
    cell_bus.padding = 1'b0;
    res_bus.ready = 1'b0;
  end

  cave_automaton_stencil_3d DUT (
    .clk_i(clk), .rst_ni(rst_n), .cell_i(cell_bus), .result_o(res_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cas_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cell_ch(cell_bus), .result(res_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .pending(pending), .results_seen(results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: too long without any accepted beat
  always @(posedge clk) begin
    if ((cell_bus.valid && cell_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout, no beat for %0d cycles", STALL_LIMIT);
      $display("[cave_automaton_stencil_3d] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, and one long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (hold_off) begin
        gap = 600;
        hold_off = 0;
      end
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
      @(negedge clk);
    end
  end

  task automatic send_beat(logic wall, logic pad);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cell_bus.valid <= 1'b1;
    cell_bus.cell_wall <= wall;
    cell_bus.padding <= pad;
    do @(posedge clk); while (!(cell_bus.valid && cell_bus.ready));
    @(negedge clk);
  endtask

  // setup, access, then idle before the next transfer
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= cas_pkg::ADDRW'({idx, 2'b00}); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int unsigned eff(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // one generation: set up, stream the cells, drain the tail, wait for idle
  task automatic run_generation(int unsigned w, int unsigned h, int unsigned d,
                                int unsigned stay, int unsigned become,
                                int dens, int noise, bit cut_short);
    int unsigned ew, eh, ed, total, lag, ncells;
    cell_bus.valid <= 1'b0;
    write_reg(cas_pkg::REG_GRID_WIDTH, w);
    write_reg(cas_pkg::REG_GRID_HEIGHT, h);
    write_reg(cas_pkg::REG_GRID_DEPTH, d);
    write_reg(cas_pkg::REG_STAY_MIN, stay);
    write_reg(cas_pkg::REG_BECOME_MIN, become);
    ew = eff(w, cas_pkg::MAX_WIDTH);
    eh = eff(h, cas_pkg::MAX_HEIGHT);
    ed = eff(d, cas_pkg::MAX_DEPTH);
    total = ew * eh * ed;
    lag = (ed > 1 ? ew * eh : 0) + (eh > 1 ? ew : 0) + (ew > 1 ? 1 : 0);
    ncells = cut_short ? $urandom_range(1, total) : total;
    for (int unsigned i = 0; i < ncells; i++) begin
      if ($urandom_range(0, 99) < noise) send_beat(1'($urandom_range(0, 1)), 1'b1);
      send_beat($urandom_range(0, 99) < dens, 1'b0);
      cells_sent++;
    end
    // drain: padding beats, or extra cells that stand in for padding
    if (!cut_short) begin
      for (int unsigned i = 0; i < lag; i++) begin
        send_beat(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
        cells_sent++;
      end
    end
    cell_bus.valid <= 1'b0;
    generations++;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    int unsigned w, h, d, stay, become;
    int          k;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: single cells, threshold extremes, cube, noise and drain
    run_generation(1, 1, 1, 0, 31, 100, 0, 0);
    run_generation(1, 1, 1, 0, 31, 0, 0, 0);
    run_generation(2, 2, 2, 26, 0, 50, 0, 0);
    run_generation(3, 1, 1, 1, 2, 50, 40, 0);
    run_generation(2, 2, 1, 31, 26, 100, 0, 0);

    // random generations, extremes of the dimensions first
    k = 0;
    while (cells_sent < 1300) begin
      quiet = ($urandom_range(0, 3) == 0);
      case (k)
        0: begin w = 64; h = 1; d = 1; end
        1: begin w = 0; h = 100; d = 1; end
        2: begin w = 1; h = 0; d = 127; end
        3: begin w = 8; h = 8; d = 2; hold_off = 1; quiet = 1; end
        default: begin
          w = $urandom_range(0, 7); h = $urandom_range(0, 6); d = $urandom_range(0, 4);
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        stay = $urandom_range(0, 31); become = $urandom_range(0, 31);
      end else begin
        stay = $urandom_range(2, 8); become = $urandom_range(3, 12);
      end
      run_generation(w, h, d, stay, become, $urandom_range(20, 80),
                     $urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 9) == 0);
      k++;
    end

    repeat (10) @(posedge clk);
    $display("%0d generations, %0d cell beats, %0d next-state beats checked",
             generations, cells_sent, results_seen);
    if (fail_count == 0) begin
      $display("[cave_automaton_stencil_3d] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[cave_automaton_stencil_3d] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/cas_pkg.sv
hdl/cas_if.sv
hdl/cas_ram.sv
hdl/cas_delay_lines.sv
hdl/cas_tap_cell.sv
hdl/cas_rule.sv
hdl/cave_automaton_stencil_3d.sv
bench/cas_checker.sv
bench/testbench.sv
